@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/ahfld_pkg.sv @@
// ----------------------------------------------------------------------------
// ahfld_pkg
// Types, character constants and hex decode for the ASCII-hex frame decoder.
// ----------------------------------------------------------------------------
package ahfld_pkg;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] HEX_BASE = 8'd10;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ODD   = 3'd1,
        ST_BAD   = 3'd2,
        ST_EMPTY = 3'd3,
        ST_LRC   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
    } t_char;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       frame_done;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex       h;
        logic [7:0] v;
        h.ok  = 1'b0;
        h.nib = 4'd0;
        v     = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            v     = c - CH_0;
            h.ok  = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v     = c - CH_UA + HEX_BASE;
            h.ok  = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v     = c - CH_LA + HEX_BASE;
            h.ok  = 1'b1;
        end
        h.nib = v[3:0];
        return h;
    endfunction

endpackage

@@ hdl/ahfld_in_stage.sv @@
// ----------------------------------------------------------------------------
// ahfld_in_stage
// Input register: holds one character beat until the core consumes it.
// ----------------------------------------------------------------------------
module ahfld_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ahfld_pkg::t_char    i_char,
    input  logic                i_advance,
    output logic                o_valid,
    output ahfld_pkg::t_char    o_char
);

    logic             r_valid;
    ahfld_pkg::t_char r_char;
    logic             accept;

    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

@@ hdl/ahfld_core.sv @@
// ----------------------------------------------------------------------------
// ahfld_core
// Frame state, hex pair decode, running sum and end-of-frame status.
// ----------------------------------------------------------------------------
module ahfld_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ahfld_pkg::t_char    i_char,
    input  logic                i_fire,
    output logic                o_has_result,
    output ahfld_pkg::t_result  o_result
);

    logic       r_pair_phase;
    logic [3:0] r_high_nibble;
    logic [7:0] r_byte_sum;
    logic       r_bad_seen;
    logic       r_byte_seen;

    logic       n_pair_phase;
    logic [3:0] n_high_nibble;
    logic [7:0] n_byte_sum;
    logic       n_bad_seen;
    logic       n_byte_seen;

    ahfld_pkg::t_hex    hex;
    ahfld_pkg::t_result res;

    assign hex = ahfld_pkg::hex_value(i_char.ch);

    always_comb begin
        n_pair_phase   = r_pair_phase;
        n_high_nibble  = r_high_nibble;
        n_byte_sum     = r_byte_sum;
        n_bad_seen     = r_bad_seen;
        n_byte_seen    = r_byte_seen;
        res.data_byte  = 8'd0;
        res.byte_valid = 1'b0;
        res.frame_done = i_char.last;
        res.status     = ahfld_pkg::ST_OK;

        if (i_char.first) begin
            n_pair_phase  = 1'b0;
            n_high_nibble = 4'd0;
            n_byte_sum    = 8'd0;
            n_bad_seen    = 1'b0;
            n_byte_seen   = 1'b0;
        end else begin
            n_bad_seen = r_bad_seen || !hex.ok;
            if (!r_pair_phase) begin
                n_high_nibble = hex.nib;
                n_pair_phase  = 1'b1;
            end else begin
                n_pair_phase = 1'b0;
                if (!n_bad_seen) begin
                    res.data_byte  = {r_high_nibble, hex.nib};
                    res.byte_valid = 1'b1;
                    n_byte_sum     = r_byte_sum + {r_high_nibble, hex.nib};
                    n_byte_seen    = 1'b1;
                end
            end
        end

        if (i_char.last) begin
            if (n_pair_phase) begin
                res.status = ahfld_pkg::ST_ODD;
            end else if (n_bad_seen) begin
                res.status = ahfld_pkg::ST_BAD;
            end else if (!n_byte_seen) begin
                res.status = ahfld_pkg::ST_EMPTY;
            end else if (n_byte_sum != 8'd0) begin
                res.status = ahfld_pkg::ST_LRC;
            end
            n_pair_phase  = 1'b0;
            n_high_nibble = 4'd0;
            n_byte_sum    = 8'd0;
            n_bad_seen    = 1'b0;
            n_byte_seen   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_phase  <= 1'b0;
            r_high_nibble <= 4'd0;
            r_byte_sum    <= 8'd0;
            r_bad_seen    <= 1'b0;
            r_byte_seen   <= 1'b0;
        end else if (i_fire) begin
            r_pair_phase  <= n_pair_phase;
            r_high_nibble <= n_high_nibble;
            r_byte_sum    <= n_byte_sum;
            r_bad_seen    <= n_bad_seen;
            r_byte_seen   <= n_byte_seen;
        end
    end

    assign o_has_result = res.byte_valid || res.frame_done;
    assign o_result     = res;

endmodule

@@ hdl/ahfld_out_stage.sv @@
// ----------------------------------------------------------------------------
// ahfld_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ahfld_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ahfld_pkg::t_result  i_result,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output ahfld_pkg::t_result  o_result
);

    logic               r_valid;
    ahfld_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/ascii_hex_frame_lrc_decoder_top.sv @@
// ----------------------------------------------------------------------------
// ascii_hex_frame_lrc_decoder_top
// ASCII-hex frame decoder with running LRC check.
// ----------------------------------------------------------------------------
// Input channel: one character beat per handshake (ch, first, last).
//   first marks the frame head: decoding state clears, the character is
//   skipped. last marks the final payload character; the tail is stripped
//   upstream.
// Output channel: a result beat per hex pair with no bad digit before it in
//   the frame and per last character, else none. frame_done with status
//   (ok, odd count, bad digit, empty, LRC mismatch) closes a frame.
// Path: a character goes through the input register and the decode; its
//   result beat, if any, is held in the result register.
// Throughput: one character per cycle unless stalled; the frame state update
//   is a single 8-bit add and compare between input and result stages.
// Reset clears both stage valids and all frame state.
// When the receiver stalls, the result register holds its beat and the
//   input register holds one further character; ready then drops until the
//   stall clears. Characters that produce no result pass through regardless.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_hex_frame_lrc_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_first,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_frame_done,
    output logic [2:0] o_status
);

    ahfld_pkg::t_char   in_char;
    ahfld_pkg::t_char   s1_char;
    ahfld_pkg::t_result core_result;
    ahfld_pkg::t_result out_result;
    logic               s1_valid;
    logic               has_result;
    logic               out_free;
    logic               advance;
    logic               load;

    assign in_char.ch    = i_ch;
    assign in_char.first = i_first;
    assign in_char.last  = i_last;

    assign advance = s1_valid && (!has_result || out_free);
    assign load    = advance && has_result;

    ahfld_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_char    (in_char),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_char    (s1_char)
    );

    ahfld_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (s1_char),
        .i_fire       (advance),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    ahfld_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_data_byte  = out_result.data_byte;
    assign o_byte_valid = out_result.byte_valid;
    assign o_frame_done = out_result.frame_done;
    assign o_status     = out_result.status;

    `ASSERT_IMPL(a_beat_has_content, i_clk, i_rst_n, o_out_valid,
        o_byte_valid || o_frame_done)
    `ASSERT_IMPL(a_status_only_at_end, i_clk, i_rst_n, o_out_valid && !o_frame_done,
        o_status == ahfld_pkg::ST_OK)
    `ASSERT_IMPL(a_data_zero_no_byte, i_clk, i_rst_n, o_out_valid && !o_byte_valid,
        o_data_byte == 8'd0)
    `ASSERT_IMPL(a_stall_means_full, i_clk, i_rst_n, !o_in_ready,
        s1_valid && o_out_valid && !i_out_ready)

endmodule

@@ test/ascii_hex_frame_lrc_decoder_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_lrc_decoder_top_test
// Self-checking bench for the ASCII-hex frame decoder with LRC check.
// ----------------------------------------------------------------------------
// Character beats go in through a valid/ready sender task. A frame tracker in
// the bench decodes each accepted character the same way the block should and
// queues the expected result beat. A checker pops and compares every result
// beat field by field. Stimulus: directed frames for digit edges and each
// status, then random frames (mostly well formed with a correct LRC, the rest
// corrupted, empty or noise) under three sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module ascii_hex_frame_lrc_decoder_top_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_ch;
    logic       i_first;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_data_byte;
    logic       o_byte_valid;
    logic       o_frame_done;
    logic [2:0] o_status;

    ascii_hex_frame_lrc_decoder_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .i_first      (i_first),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_frame_done (o_frame_done),
        .o_status     (o_status)
    );

    // frame tracker state
    logic       nib_pending;
    logic [3:0] high_nib;
    logic [7:0] lrc_sum;
    logic       bad_char_seen;
    logic       any_byte_seen;

    ahfld_pkg::t_result frame_results_due[$];
    ahfld_pkg::t_result want;
    int         err_count;
    int         chars_sent;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         stall_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] nib);
        logic [7:0] v;
        v         = 8'd0;
        hex_digit = 1'b1;
        if (c >= ahfld_pkg::CH_0 && c <= ahfld_pkg::CH_9) begin
            v = c - ahfld_pkg::CH_0;
        end else if (c >= ahfld_pkg::CH_UA && c <= ahfld_pkg::CH_UF) begin
            v = c - ahfld_pkg::CH_UA + ahfld_pkg::HEX_BASE;
        end else if (c >= ahfld_pkg::CH_LA && c <= ahfld_pkg::CH_LF) begin
            v = c - ahfld_pkg::CH_LA + ahfld_pkg::HEX_BASE;
        end else begin
            hex_digit = 1'b0;
        end
        nib = v[3:0];
    endfunction

    function automatic logic [7:0] nib_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return ahfld_pkg::CH_0 + {4'd0, n};
        end
        return ($urandom_range(1) ? ahfld_pkg::CH_UA : ahfld_pkg::CH_LA) + {4'd0, n}
               - ahfld_pkg::HEX_BASE;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] nib;
        do begin
            c = 8'($urandom_range(255));
        end while (hex_digit(c, nib));
        return c;
    endfunction

    task automatic clear_frame_state();
        nib_pending   = 1'b0;
        high_nib      = 4'd0;
        lrc_sum       = 8'd0;
        bad_char_seen = 1'b0;
        any_byte_seen = 1'b0;
    endtask

    task automatic track_frame(input logic [7:0] c, input logic f, input logic l);
        ahfld_pkg::t_result r;
        logic [3:0] nib;
        logic       ok;
        r        = '0;
        r.status = ahfld_pkg::ST_OK;
        if (f) begin
            clear_frame_state();
        end else begin
            ok = hex_digit(c, nib);
            if (!ok) begin
                bad_char_seen = 1'b1;
            end
            if (!nib_pending) begin
                high_nib    = nib;
                nib_pending = 1'b1;
            end else begin
                nib_pending = 1'b0;
                if (!bad_char_seen) begin
                    r.data_byte   = {high_nib, nib};
                    r.byte_valid  = 1'b1;
                    lrc_sum       = lrc_sum + r.data_byte;
                    any_byte_seen = 1'b1;
                end
            end
        end
        if (l) begin
            r.frame_done = 1'b1;
            if (nib_pending) begin
                r.status = ahfld_pkg::ST_ODD;
            end else if (bad_char_seen) begin
                r.status = ahfld_pkg::ST_BAD;
            end else if (!any_byte_seen) begin
                r.status = ahfld_pkg::ST_EMPTY;
            end else if (lrc_sum != 8'd0) begin
                r.status = ahfld_pkg::ST_LRC;
            end
            clear_frame_state();
        end
        if (r.byte_valid || l) begin
            frame_results_due.push_back(r);
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic f, input logic l);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_first    <= f;
        i_last     <= l;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        track_frame(c, f, l);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic with_head);
        if (with_head) begin
            send_char(":", 1'b1, 1'b0);
        end
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], 1'b0, i == s.len() - 1);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] chars[$];
        logic [7:0] acc;
        logic [7:0] b;
        int         kind;
        int         nbytes;
        int         idx;
        kind   = $urandom_range(99);
        nbytes = $urandom_range(7);
        acc    = 8'd0;
        if ($urandom_range(9) != 0) begin
            send_char(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        if (kind < 86) begin
            for (int i = 0; i <= nbytes; i++) begin
                if (i < nbytes) begin
                    b   = 8'($urandom_range(255));
                    acc = acc + b;
                end else begin
                    b = 8'd0 - acc;
                    if (kind >= 60 && kind < 70) begin
                        b = b ^ (8'd1 << $urandom_range(7));
                    end
                end
                chars.push_back(nib_char(b[7:4]));
                chars.push_back(nib_char(b[3:0]));
            end
            idx = $urandom_range(chars.size() - 1);
            if (kind >= 70 && kind < 78) begin
                chars.delete(idx);
            end else if (kind >= 78) begin
                chars[idx] = non_hex_char();
            end
            foreach (chars[i]) begin
                send_char(chars[i], 1'b0, i == chars.size() - 1);
            end
        end else if (kind < 90) begin
            send_char(8'($urandom_range(255)), 1'b1, 1'b1);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_char(8'($urandom_range(255)), $urandom_range(7) == 0,
                          $urandom_range(3) == 0);
            end
        end
    endtask

    task automatic run_random(input int snd_pct, input int rcv_pct, input int n_chars);
        int stop_at;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        stop_at       = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            send_random_frame();
        end
    endtask

    task automatic test_directed_frames();
        send_idle_pct = 22;
        recv_idle_pct = 49;
        send_text("09AfaF", 1'b1);        // digit edges, LRC mismatch
        send_text("00", 1'b1);            // single zero byte is ok
        send_char(8'hFF, 1'b1, 1'b1);     // head and last together: empty
        send_text("1", 1'b1);             // odd count
        send_text("/:@G`g", 1'b1);        // chars just outside each hex range
        send_text("FF01", 1'b0);          // no head after last: ok
        send_char(8'h00, 1'b0, 1'b0);
        send_char(8'h7F, 1'b0, 1'b1);     // control chars: bad digit
    endtask

    task automatic test_random_sender_idle();
        run_random(22, 49, 510);
    endtask

    task automatic test_random_receiver_idle();
        run_random(49, 22, 510);
    endtask

    task automatic test_random_streaming();
        run_random(0, 0, 510);
    endtask

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_results_due.size() == 0) begin
                report_error($sformatf("unexpected beat: data %h valid %b done %b status %0d",
                                       o_data_byte, o_byte_valid, o_frame_done, o_status));
            end else begin
                want = frame_results_due.pop_front();
                if (o_data_byte !== want.data_byte || o_byte_valid !== want.byte_valid ||
                    o_frame_done !== want.frame_done || o_status !== want.status) begin
                    report_error($sformatf({"beat error: expected data %h valid %b done %b ",
                                            "status %0d, got data %h valid %b done %b status %0d"},
                                           want.data_byte, want.byte_valid, want.frame_done,
                                           want.status, o_data_byte, o_byte_valid,
                                           o_frame_done, o_status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_ch          = 8'd0;
        i_first       = 1'b0;
        i_last        = 1'b0;
        chars_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clear_frame_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_random_sender_idle();
        test_random_receiver_idle();
        test_random_streaming();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
